[rtl/core/fmsp_pkg.sv]
// fmsp_pkg: types, character codes and mask tables for the file-mode string parser
// used by fmsp_step and file_mode_string_parser_top; no dependencies

package fmsp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned ModeW   = 12;
  localparam int unsigned StatusW = 2;

  localparam logic [ModeW-1:0] AllBits = 12'o7777;

  // character codes
  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChU     = 8'h75;
  localparam logic [CharW-1:0] ChG     = 8'h67;
  localparam logic [CharW-1:0] ChO     = 8'h6f;
  localparam logic [CharW-1:0] ChA     = 8'h61;
  localparam logic [CharW-1:0] ChR     = 8'h72;
  localparam logic [CharW-1:0] ChW     = 8'h77;
  localparam logic [CharW-1:0] ChX     = 8'h78;
  localparam logic [CharW-1:0] ChS     = 8'h73;
  localparam logic [CharW-1:0] ChT     = 8'h74;
  localparam logic [CharW-1:0] ChEq    = 8'h3d;
  localparam logic [CharW-1:0] ChPlus  = 8'h2b;
  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChComma = 8'h2c;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChSeven = 8'h37;

  typedef enum logic [2:0] {
    PH_GROUP = 3'd0,
    PH_MODE  = 3'd1,
    PH_OCTAL = 3'd2,
    PH_SKIP  = 3'd3
  } phase_e;

  typedef enum logic [1:0] {
    OUT_NONE   = 2'd0,
    OUT_MASKS  = 2'd1,
    OUT_OCTAL  = 2'd2,
    OUT_REJECT = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    OP_ASSIGN = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  localparam logic [StatusW-1:0] StatusOk         = 2'd0;
  localparam logic [StatusW-1:0] StatusRejected   = 2'd1;
  localparam logic [StatusW-1:0] StatusIncomplete = 2'd2;

  // parser state carried between characters
  typedef struct packed {
    phase_e           phase;
    logic [ModeW-1:0] group_mask;
    logic [ModeW-1:0] perm_mask;
    op_e              op_kind;
    logic [ModeW-1:0] keep_mask;
    logic [ModeW-1:0] set_mask;
    logic [ModeW-1:0] octal_value;
    outcome_e         outcome;
  } parser_state_t;

  localparam parser_state_t StateReset = '{
    phase:       PH_GROUP,
    group_mask:  '0,
    perm_mask:   '0,
    op_kind:     OP_ASSIGN,
    keep_mask:   AllBits,
    set_mask:    '0,
    octal_value: '0,
    outcome:     OUT_NONE
  };

  // one finished result
  typedef struct packed {
    logic               valid;
    logic [ModeW-1:0]   new_mode;
    logic [StatusW-1:0] status;
  } result_t;

  typedef struct packed {
    logic [ModeW-1:0] keep_mask;
    logic [ModeW-1:0] set_mask;
  } masks_t;

  function automatic logic [ModeW-1:0] group_bits(input logic [CharW-1:0] ch);
    logic [ModeW-1:0] bits;
    unique case (ch)
      ChU:     bits = 12'o4700;
      ChG:     bits = 12'o2070;
      ChO:     bits = 12'o0007;
      ChA:     bits = 12'o7777;
      default: bits = '0;
    endcase
    return bits;
  endfunction

  function automatic logic [ModeW-1:0] perm_bits(input logic [CharW-1:0] ch);
    logic [ModeW-1:0] bits;
    unique case (ch)
      ChR:     bits = 12'o0444;
      ChW:     bits = 12'o0222;
      ChX:     bits = 12'o0111;
      ChS:     bits = 12'o6000;
      ChT:     bits = 12'o1000;
      default: bits = '0;
    endcase
    return bits;
  endfunction

  // fold the open clause into the keep and set masks
  function automatic masks_t apply_clause(input parser_state_t st);
    masks_t           m;
    logic [ModeW-1:0] sel;
    sel = st.perm_mask & st.group_mask;
    m.keep_mask = st.keep_mask;
    m.set_mask  = st.set_mask;
    unique case (st.op_kind)
      OP_ASSIGN: begin
        m.keep_mask = st.keep_mask & ~st.group_mask;
        m.set_mask  = (st.set_mask & ~st.group_mask) | sel;
      end
      OP_ADD: begin
        m.set_mask = st.set_mask | sel;
      end
      default: begin
        m.keep_mask = st.keep_mask & ~sel;
        m.set_mask  = st.set_mask & ~sel;
      end
    endcase
    return m;
  endfunction

endpackage

[rtl/core/fmsp_step.sv]
// fmsp_step: next-state and result logic for one character of the mode string
// depends on fmsp_pkg

module fmsp_step (
  input  fmsp_pkg::parser_state_t        state_i,
  input  logic [fmsp_pkg::CharW-1:0]     character_i,
  input  logic [fmsp_pkg::ModeW-1:0]     old_mode_i,
  output fmsp_pkg::parser_state_t        state_o,
  output fmsp_pkg::result_t              result_o
);

  fmsp_pkg::masks_t           clause;
  fmsp_pkg::masks_t           applied;
  logic [fmsp_pkg::ModeW-1:0] gbits;
  logic [fmsp_pkg::ModeW-1:0] pbits;
  logic                       is_op;
  logic                       is_octal;
  logic [fmsp_pkg::ModeW-1:0] octal_next;

  // character classes
  assign clause   = fmsp_pkg::apply_clause(state_i);
  assign gbits    = fmsp_pkg::group_bits(character_i);
  assign pbits    = fmsp_pkg::perm_bits(character_i);
  assign is_op    = (character_i == fmsp_pkg::ChEq) || (character_i == fmsp_pkg::ChPlus) ||
                    (character_i == fmsp_pkg::ChMinus);
  assign is_octal = (character_i >= fmsp_pkg::ChZero) && (character_i <= fmsp_pkg::ChSeven);

  // octal accumulate, saturating once the value has reached 01000
  assign octal_next = (state_i.octal_value[11:9] != 3'd0) ? fmsp_pkg::AllBits :
                      {state_i.octal_value[8:0], character_i[2:0]};

  // result on the terminator
  always_comb begin
    result_o.valid    = (character_i == fmsp_pkg::ChNul);
    result_o.new_mode = old_mode_i;
    result_o.status   = fmsp_pkg::StatusOk;
    applied           = clause;
    priority if (state_i.phase == fmsp_pkg::PH_GROUP) begin
      result_o.status = fmsp_pkg::StatusIncomplete;
    end else if (state_i.phase == fmsp_pkg::PH_MODE) begin
      result_o.new_mode = (old_mode_i & clause.keep_mask) | clause.set_mask;
    end else if (state_i.phase == fmsp_pkg::PH_OCTAL ||
                 state_i.outcome == fmsp_pkg::OUT_OCTAL) begin
      result_o.new_mode = state_i.octal_value;
    end else if (state_i.outcome == fmsp_pkg::OUT_REJECT) begin
      result_o.status = fmsp_pkg::StatusRejected;
    end else begin
      // masks outcome: the open clause was dropped
      applied.keep_mask = state_i.keep_mask;
      applied.set_mask  = state_i.set_mask;
      result_o.new_mode = (old_mode_i & applied.keep_mask) | applied.set_mask;
    end
  end

  // next state
  always_comb begin
    state_o = state_i;
    if (character_i == fmsp_pkg::ChNul) begin
      state_o = fmsp_pkg::StateReset;
    end else begin
      unique case (state_i.phase)
        fmsp_pkg::PH_GROUP: begin
          priority if (gbits != '0) begin
            state_o.group_mask = state_i.group_mask | gbits;
          end else if (is_op) begin
            state_o.op_kind = (character_i == fmsp_pkg::ChEq)   ? fmsp_pkg::OP_ASSIGN :
                              (character_i == fmsp_pkg::ChPlus) ? fmsp_pkg::OP_ADD :
                                                                  fmsp_pkg::OP_REMOVE;
            if (state_i.group_mask == '0) begin
              state_o.group_mask = fmsp_pkg::AllBits;
            end
            state_o.perm_mask = '0;
            state_o.phase     = fmsp_pkg::PH_MODE;
          end else if (is_octal && state_i.group_mask == '0) begin
            state_o.octal_value = {9'd0, character_i[2:0]};
            state_o.phase       = fmsp_pkg::PH_OCTAL;
          end else begin
            state_o.outcome = fmsp_pkg::OUT_REJECT;
            state_o.phase   = fmsp_pkg::PH_SKIP;
          end
        end
        fmsp_pkg::PH_MODE: begin
          priority if (pbits != '0) begin
            state_o.perm_mask = state_i.perm_mask | pbits;
          end else if (character_i == fmsp_pkg::ChComma) begin
            state_o.keep_mask  = clause.keep_mask;
            state_o.set_mask   = clause.set_mask;
            state_o.group_mask = '0;
            state_o.perm_mask  = '0;
            state_o.phase      = fmsp_pkg::PH_GROUP;
          end else begin
            state_o.outcome = fmsp_pkg::OUT_MASKS;
            state_o.phase   = fmsp_pkg::PH_SKIP;
          end
        end
        fmsp_pkg::PH_OCTAL: begin
          if (is_octal) begin
            state_o.octal_value = octal_next;
          end else begin
            state_o.outcome = fmsp_pkg::OUT_OCTAL;
            state_o.phase   = fmsp_pkg::PH_SKIP;
          end
        end
        default: begin
          // decided: ignore until the terminator
          state_o = state_i;
        end
      endcase
    end
  end

endmodule

[rtl/core/file_mode_string_parser_top.sv]
// file_mode_string_parser_top: stream wrapper with parser state and result register
// depends on fmsp_pkg and fmsp_step

// Parses a file-mode string (symbolic clauses like "u+x,go-w" or an octal number) fed one
// byte per transaction on the slave stream; a zero byte ends the string and yields one
// result transaction with the new 12-bit mode and a status (0 ok, 1 rejected, 2 incomplete).
// The parser state and the output register are both loaded at the edge that accepts a
// byte, so a terminator's result is offered in the next cycle. Input is accepted whenever
// the output register is empty or is being drained, so a fully ready sink sees one byte
// per clock. Bytes other than the terminator produce no output transaction.

module file_mode_string_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] character, [19:8] old_mode, [23:20] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [11:0] new_mode, [13:12] status, [15:14] zero
);

  fmsp_pkg::parser_state_t        state_q;
  fmsp_pkg::parser_state_t        state_d;
  fmsp_pkg::result_t              result;
  logic                           out_valid_q;
  logic [fmsp_pkg::ModeW-1:0]     new_mode_q;
  logic [fmsp_pkg::StatusW-1:0]   status_q;
  logic                           in_xact;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xact       = s_axis_tvalid && s_axis_tready;

  fmsp_step u_step (
    .state_i     (state_q),
    .character_i (s_axis_tdata[7:0]),
    .old_mode_i  (s_axis_tdata[19:8]),
    .state_o     (state_d),
    .result_o    (result)
  );

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmsp_pkg::StateReset;
    end else if (in_xact) begin
      state_q <= state_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xact) begin
      out_valid_q <= result.valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_xact && result.valid) begin
      new_mode_q <= result.new_mode;
      status_q   <= result.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, status_q, new_mode_q};

  // a terminator always returns the parser to its start and posts a result
  a_term_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xact && s_axis_tdata[7:0] == fmsp_pkg::ChNul)
      |=> (state_q.phase == fmsp_pkg::PH_GROUP && m_axis_tvalid))
    else $error("terminator did not reset parser or post result");

  // an ordinary byte never creates a result when the sink drains
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xact && s_axis_tdata[7:0] != fmsp_pkg::ChNul && m_axis_tready) |=> !m_axis_tvalid)
    else $error("result posted for a non-terminator byte");

  // skip phase only after an outcome has been decided
  a_skip_decided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == fmsp_pkg::PH_SKIP) |-> (state_q.outcome != fmsp_pkg::OUT_NONE))
    else $error("skip phase without a decided outcome");

  // status never goes past the incomplete code
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (status_q <= fmsp_pkg::StatusIncomplete))
    else $error("invalid status code");

endmodule

[dv/file_mode_string_parser_top_test.sv]
// file_mode_string_parser_top_test: self-checking stream testbench for the file-mode parser
// drives mode strings byte by byte, predicts each terminator's result and checks the output
// depends on fmsp_pkg and file_mode_string_parser_top
`timescale 1ns / 1ps

module file_mode_string_parser_top_test;

  localparam int unsigned CharW   = fmsp_pkg::CharW;
  localparam int unsigned ModeW   = fmsp_pkg::ModeW;
  localparam int unsigned StatusW = fmsp_pkg::StatusW;

  localparam int IdleLimit  = 2000;
  localparam int HoldoffLen = 80;
  localparam int PhaseChars = 210;

  localparam logic [CharW-1:0] ChEight = 8'h38;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic [ModeW-1:0] old_mode;
  } mode_char_t;

  typedef struct packed {
    logic [ModeW-1:0]   new_mode;
    logic [StatusW-1:0] status;
  } mode_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  mode_char_t   char_q[$];
  mode_result_t mode_expect_q[$];
  logic [7:0]   str_buf[$];

  int err_count     = 0;
  int chars_queued  = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int holdoff_req   = 0;
  int holdoff_ack   = 0;
  int holdoff_left  = 0;
  int quiet_cycles  = 0;

  // parser state mirrored by the predictor
  fmsp_pkg::phase_e   prs_phase = fmsp_pkg::PH_GROUP;
  logic [ModeW-1:0]   grp_sel   = '0;
  logic [ModeW-1:0]   perm_sel  = '0;
  fmsp_pkg::op_e      op_cur    = fmsp_pkg::OP_ASSIGN;
  logic [ModeW-1:0]   keep_bits = fmsp_pkg::AllBits;
  logic [ModeW-1:0]   or_bits   = '0;
  logic [ModeW-1:0]   oct_acc   = '0;
  fmsp_pkg::outcome_e verdict   = fmsp_pkg::OUT_NONE;

  file_mode_string_parser_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [ModeW-1:0] group_select(input logic [CharW-1:0] ch);
    case (ch)
      fmsp_pkg::ChU: return 12'o4700;
      fmsp_pkg::ChG: return 12'o2070;
      fmsp_pkg::ChO: return 12'o0007;
      fmsp_pkg::ChA: return 12'o7777;
      default:       return '0;
    endcase
  endfunction

  function automatic logic [ModeW-1:0] perm_select(input logic [CharW-1:0] ch);
    case (ch)
      fmsp_pkg::ChR: return 12'o0444;
      fmsp_pkg::ChW: return 12'o0222;
      fmsp_pkg::ChX: return 12'o0111;
      fmsp_pkg::ChS: return 12'o6000;
      fmsp_pkg::ChT: return 12'o1000;
      default:       return '0;
    endcase
  endfunction

  function automatic bit is_octal_digit(input logic [CharW-1:0] ch);
    return ch >= fmsp_pkg::ChZero && ch <= fmsp_pkg::ChSeven;
  endfunction

  // merge the open clause into the and/or masks
  task automatic fold_clause();
    logic [ModeW-1:0] sel;
    sel = perm_sel & grp_sel;
    case (op_cur)
      fmsp_pkg::OP_ASSIGN: begin
        keep_bits = keep_bits & ~grp_sel;
        or_bits   = (or_bits & ~grp_sel) | sel;
      end
      fmsp_pkg::OP_ADD: begin
        or_bits = or_bits | sel;
      end
      default: begin
        keep_bits = keep_bits & ~sel;
        or_bits   = or_bits & ~sel;
      end
    endcase
  endtask

  task automatic clear_parser();
    prs_phase = fmsp_pkg::PH_GROUP;
    grp_sel   = '0;
    perm_sel  = '0;
    op_cur    = fmsp_pkg::OP_ASSIGN;
    keep_bits = fmsp_pkg::AllBits;
    or_bits   = '0;
    oct_acc   = '0;
    verdict   = fmsp_pkg::OUT_NONE;
  endtask

  // advance the mirrored parser by one accepted byte
  task automatic predict_mode_char(input logic [CharW-1:0] ch, input logic [ModeW-1:0] old);
    logic [ModeW-1:0] who;
    logic [ModeW-1:0] rights;
    logic [CharW-1:0] digit;
    mode_result_t     r;
    digit = ch - fmsp_pkg::ChZero;
    if (ch == fmsp_pkg::ChNul) begin
      r.new_mode = old;
      r.status   = fmsp_pkg::StatusOk;
      case (prs_phase)
        fmsp_pkg::PH_GROUP: r.status = fmsp_pkg::StatusIncomplete;
        fmsp_pkg::PH_MODE: begin
          fold_clause();
          r.new_mode = (old & keep_bits) | or_bits;
        end
        fmsp_pkg::PH_OCTAL: r.new_mode = oct_acc;
        default: begin
          if (verdict == fmsp_pkg::OUT_OCTAL) r.new_mode = oct_acc;
          else if (verdict == fmsp_pkg::OUT_REJECT) r.status = fmsp_pkg::StatusRejected;
          else r.new_mode = (old & keep_bits) | or_bits;
        end
      endcase
      mode_expect_q.push_back(r);
      clear_parser();
    end else begin
      case (prs_phase)
        fmsp_pkg::PH_GROUP: begin
          who = group_select(ch);
          if (who != '0) begin
            grp_sel = grp_sel | who;
          end else if (ch == fmsp_pkg::ChEq || ch == fmsp_pkg::ChPlus ||
                       ch == fmsp_pkg::ChMinus) begin
            op_cur = (ch == fmsp_pkg::ChEq)   ? fmsp_pkg::OP_ASSIGN :
                     (ch == fmsp_pkg::ChPlus) ? fmsp_pkg::OP_ADD : fmsp_pkg::OP_REMOVE;
            if (grp_sel == '0) grp_sel = fmsp_pkg::AllBits;
            perm_sel  = '0;
            prs_phase = fmsp_pkg::PH_MODE;
          end else if (is_octal_digit(ch) && grp_sel == '0) begin
            oct_acc   = ModeW'(digit);
            prs_phase = fmsp_pkg::PH_OCTAL;
          end else begin
            verdict   = fmsp_pkg::OUT_REJECT;
            prs_phase = fmsp_pkg::PH_SKIP;
          end
        end
        fmsp_pkg::PH_MODE: begin
          rights = perm_select(ch);
          if (rights != '0) begin
            perm_sel = perm_sel | rights;
          end else if (ch == fmsp_pkg::ChComma) begin
            fold_clause();
            grp_sel   = '0;
            perm_sel  = '0;
            prs_phase = fmsp_pkg::PH_GROUP;
          end else begin
            verdict   = fmsp_pkg::OUT_MASKS;
            prs_phase = fmsp_pkg::PH_SKIP;
          end
        end
        fmsp_pkg::PH_OCTAL: begin
          if (is_octal_digit(ch)) begin
            if (oct_acc >= 12'd512) oct_acc = fmsp_pkg::AllBits;
            else oct_acc = {oct_acc[ModeW-4:0], digit[2:0]};
          end else begin
            verdict   = fmsp_pkg::OUT_OCTAL;
            prs_phase = fmsp_pkg::PH_SKIP;
          end
        end
        default: ;
      endcase
    end
  endtask

  // byte driver: holds data while stalled, idles at random between transactions
  always @(posedge clk_i) begin : drive_chars
    mode_char_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_mode_char(s_axis_tdata[7:0], s_axis_tdata[19:8]);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = char_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0000, nxt.old_mode, nxt.ch};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and sink backpressure
  always @(posedge clk_i) begin : watch_results
    mode_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (mode_expect_q.size() == 0) begin
          flag_error($sformatf("unexpected result transaction, tdata=%h", m_axis_tdata));
        end else begin
          want = mode_expect_q.pop_front();
          if (m_axis_tdata[11:0] !== want.new_mode)
            flag_error($sformatf("new_mode got %o want %o", m_axis_tdata[11:0],
                                 want.new_mode));
          if (m_axis_tdata[13:12] !== want.status)
            flag_error($sformatf("status got %0d want %0d", m_axis_tdata[13:12],
                                 want.status));
        end
      end
      // long hold-off on request, otherwise random stalls
      if (holdoff_left > 0) begin
        holdoff_left  <= holdoff_left - 1;
        m_axis_tready <= 1'b0;
      end else if (holdoff_req != holdoff_ack) begin
        holdoff_ack   <= holdoff_req;
        holdoff_left  <= HoldoffLen;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // string building helpers
  task automatic add_char(input logic [7:0] ch);
    str_buf.push_back(ch);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
  endtask

  // queue the built string plus its terminator
  task automatic flush_string(input logic [ModeW-1:0] old);
    mode_char_t it;
    foreach (str_buf[i]) begin
      it.ch       = str_buf[i];
      it.old_mode = ModeW'($urandom_range(4095));
      char_q.push_back(it);
    end
    it.ch       = fmsp_pkg::ChNul;
    it.old_mode = old;
    char_q.push_back(it);
    chars_queued += str_buf.size() + 1;
    str_buf.delete();
  endtask

  function automatic logic [7:0] pick_group();
    case ($urandom_range(3))
      0:       return fmsp_pkg::ChU;
      1:       return fmsp_pkg::ChG;
      2:       return fmsp_pkg::ChO;
      default: return fmsp_pkg::ChA;
    endcase
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(2))
      0:       return fmsp_pkg::ChEq;
      1:       return fmsp_pkg::ChPlus;
      default: return fmsp_pkg::ChMinus;
    endcase
  endfunction

  function automatic logic [7:0] pick_perm();
    case ($urandom_range(4))
      0:       return fmsp_pkg::ChR;
      1:       return fmsp_pkg::ChW;
      2:       return fmsp_pkg::ChX;
      3:       return fmsp_pkg::ChS;
      default: return fmsp_pkg::ChT;
    endcase
  endfunction

  function automatic logic [7:0] pick_noise();
    return 8'($urandom_range(1, 255));
  endfunction

  // a random octal or decimal digit character
  function automatic logic [7:0] pick_digit(input int unsigned top);
    return 8'(fmsp_pkg::ChZero + $urandom_range(top));
  endfunction

  // a byte that ends a permission list early
  function automatic logic [7:0] pick_bad_perm();
    logic [7:0] ch;
    do ch = pick_noise();
    while (perm_select(ch) != '0 || ch == fmsp_pkg::ChComma);
    return ch;
  endfunction

  // a byte that cannot open a clause
  function automatic logic [7:0] pick_bad_opener();
    logic [7:0] ch;
    case ($urandom_range(3))
      0: return fmsp_pkg::ChComma;
      1: return ChEight;
      default: begin
        do ch = pick_noise();
        while (group_select(ch) != '0 || ch == fmsp_pkg::ChEq || ch == fmsp_pkg::ChPlus ||
               ch == fmsp_pkg::ChMinus || is_octal_digit(ch));
        return ch;
      end
    endcase
  endfunction

  task automatic add_clause();
    repeat ($urandom_range(3)) add_char(pick_group());
    add_char(pick_op());
    repeat ($urandom_range(4)) add_char(pick_perm());
  endtask

  task automatic add_tail();
    repeat ($urandom_range(3)) add_char(pick_noise());
  endtask

  // one random string: mostly well formed, some broken, some noise
  task automatic gen_mode_string();
    int               kind;
    logic [ModeW-1:0] old;
    kind = $urandom_range(99);
    if (kind < 55) begin
      add_clause();
      repeat ($urandom_range(2)) begin
        add_char(fmsp_pkg::ChComma);
        add_clause();
      end
      if ($urandom_range(99) < 15) begin
        add_char(pick_bad_perm());
        add_tail();
      end
    end else if (kind < 70) begin
      if ($urandom_range(99) < 20) begin
        add_clause();
        add_char(fmsp_pkg::ChComma);
      end
      repeat ($urandom_range(1, 6)) add_char(pick_digit(7));
      if ($urandom_range(99) < 40) begin
        add_char(pick_noise());
        add_tail();
      end
    end else if (kind < 88) begin
      case ($urandom_range(4))
        0: begin
          repeat ($urandom_range(1, 3)) add_char(pick_group());
          add_char(pick_digit(9));
        end
        1: add_char(pick_bad_opener());
        2: begin
          add_clause();
          add_char(fmsp_pkg::ChComma);
        end
        3: repeat ($urandom_range(1, 3)) add_char(pick_group());
        default: ;
      endcase
      if ($urandom_range(1) == 1) add_tail();
    end else begin
      repeat ($urandom_range(6)) add_char(pick_noise());
    end
    case ($urandom_range(9))
      0:       old = '0;
      1:       old = fmsp_pkg::AllBits;
      default: old = ModeW'($urandom_range(4095));
    endcase
    flush_string(old);
  endtask

  // wait until every queued byte is taken and every result has come back
  task automatic wait_all_done();
    while (char_q.size() != 0 || s_axis_tvalid || mode_expect_q.size() != 0)
      @(negedge clk_i);
  endtask

  // stimulus sequence
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed strings
    flush_string(12'o0000);
    add_text("ou");
    flush_string(12'o7777);
    add_text("a-r,");
    flush_string(12'o0644);
    add_text("g+wt,=xs");
    flush_string(12'o0000);
    add_text("u7");
    flush_string(12'o0755);
    add_text("o+rz");
    add_char(8'hff);
    flush_string(12'o0777);
    add_text("=,40000");
    flush_string(12'o0123);
    add_text(",");
    flush_string(12'o0644);
    wait_all_done();

    // random strings under each idling mix, pausing between mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          holdoff_req++;
        end
        1: begin
          send_idle_pct = 86;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 86;
        end
        default: begin
          send_idle_pct = 18;
          stall_pct     = 18;
        end
      endcase
      begin : fill_phase
        int target;
        target = chars_queued + PhaseChars;
        while (chars_queued < target) gen_mode_string();
      end
      wait_all_done();
    end

    repeat (8) @(negedge clk_i);
    if (mode_expect_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", mode_expect_q.size()));
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
